// ===== design/usm_pkg.sv =====
// Shared constants and types of the separable unsharp mask core.
package usm_pkg;

  localparam int DEF_MAX_HALF_TAPS = 3;
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 16384;

  localparam int PIX_W  = 16;
  localparam int FILT_W = 24;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_HALF_TAPS    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TAP_CENTER   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_TAP_ONE      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_TAP_TWO      = 3'd3;
  localparam logic [IDX_W-1:0] CFG_TAP_THREE    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SHARPEN_GAIN = 3'd5;
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd7;

  // Line store access controls issued by the sequencer.
  typedef struct packed {
    logic frd;  // read a row-filtered value
    logic rrd;  // read a raw center value
    logic wr;   // write both stores at the current column
  } mem_ctrl_t;

endpackage

// ===== design/usm_line_store.sv =====
// Line memories holding row-filtered values and raw center values.
module usm_line_store #(
  parameter int MAX_HALF_TAPS = usm_pkg::DEF_MAX_HALF_TAPS,
  parameter int MAX_WIDTH     = usm_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  usm_pkg::mem_ctrl_t              ctrl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    x_i,
  input  logic [$clog2(2*MAX_HALF_TAPS)-1:0] frd_slot_i,
  input  logic [((MAX_HALF_TAPS > 1) ? $clog2(MAX_HALF_TAPS) : 1)-1:0] rrd_slot_i,
  input  logic [$clog2(2*MAX_HALF_TAPS)-1:0] fwr_slot_i,
  input  logic [((MAX_HALF_TAPS > 1) ? $clog2(MAX_HALF_TAPS) : 1)-1:0] rwr_slot_i,
  input  logic [usm_pkg::FILT_W-1:0]      fwr_data_i,
  input  logic [usm_pkg::PIX_W-1:0]       rwr_data_i,
  output logic [usm_pkg::FILT_W-1:0]      frd_data_o,
  output logic [usm_pkg::PIX_W-1:0]       rrd_data_o
);

  localparam int FROWS = 2 * MAX_HALF_TAPS;

  logic [usm_pkg::FILT_W-1:0] filt_mem [FROWS][MAX_WIDTH];
  logic [usm_pkg::PIX_W-1:0]  raw_mem  [MAX_HALF_TAPS][MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      filt_mem[fwr_slot_i][x_i] <= fwr_data_i;
    end
    if (ctrl_i.frd) begin
      frd_data_o <= filt_mem[frd_slot_i][x_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      raw_mem[rwr_slot_i][x_i] <= rwr_data_i;
    end
    if (ctrl_i.rrd) begin
      rrd_data_o <= raw_mem[rrd_slot_i][x_i];
    end
  end

endmodule

// ===== design/separable_unsharp_mask_core.sv =====
// Top level of the separable unsharp mask core: sequencer and arithmetic.
//
// Pixels enter in raster order, one transfer at a time. A pixel whose column is
// within 2*h of the row start (h = half taps) is only shifted into the window.
// Any other pixel runs through one shared multiply-accumulate unit: row blur,
// rounding, then, from row 2*h on, column blur reading one entry per cycle from
// the line memory, then the difference, the sharpening product in two halves,
// result and write back. A result waits in an output register, so a stalled
// output only holds the block once the next result is ready. Configuration is
// to be written only while the block is idle; the block does not enforce this.
// The line memories need no clearing after reset.
module separable_unsharp_mask_core #(
  parameter int MAX_HALF_TAPS = usm_pkg::DEF_MAX_HALF_TAPS,
  parameter int MAX_WIDTH     = usm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = usm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [usm_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [usm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [usm_pkg::PIX_W-1:0]         pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [usm_pkg::PIX_W-1:0]         sharp_value_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      out_x_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]     out_y_o,
  output logic                              frame_last_o
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int WIN_LEN = 2 * MAX_HALF_TAPS + 1;
  localparam int IW      = $clog2(WIN_LEN);
  localparam int FROWS   = 2 * MAX_HALF_TAPS;
  localparam int FSW     = $clog2(FROWS);
  localparam int RSW     = (MAX_HALF_TAPS > 1) ? $clog2(MAX_HALF_TAPS) : 1;
  localparam int PW      = usm_pkg::PIX_W;
  localparam int FW      = usm_pkg::FILT_W;
  localparam int AW      = 48;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HMAC = 4'd1;
  localparam logic [3:0] S_FCUR = 4'd2;
  localparam logic [3:0] S_VMAC = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_MLO  = 4'd5;
  localparam logic [3:0] S_MHI  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;

  // Configuration registers.
  logic [1:0]    half_taps_q;
  logic [PW-1:0] tap_center_q, tap_one_q, tap_two_q, tap_three_q, gain_q;
  logic [12:0]   frame_width_q;
  logic [14:0]   frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_taps_q    <= 2'd1;
      tap_center_q   <= 16'hFFFF;
      tap_one_q      <= '0;
      tap_two_q      <= '0;
      tap_three_q    <= '0;
      gain_q         <= '0;
      frame_width_q  <= 13'd4096;
      frame_height_q <= 15'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        usm_pkg::CFG_HALF_TAPS:    half_taps_q    <= cfg_wdata_i[1:0];
        usm_pkg::CFG_TAP_CENTER:   tap_center_q   <= cfg_wdata_i;
        usm_pkg::CFG_TAP_ONE:      tap_one_q      <= cfg_wdata_i;
        usm_pkg::CFG_TAP_TWO:      tap_two_q      <= cfg_wdata_i;
        usm_pkg::CFG_TAP_THREE:    tap_three_q    <= cfg_wdata_i;
        usm_pkg::CFG_SHARPEN_GAIN: gain_q         <= cfg_wdata_i;
        usm_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[12:0];
        usm_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry and kernel size.
  logic [1:0]    h_eff;
  logic [2:0]    two_h;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] ht_eff;

  always_comb begin
    if (half_taps_q == 2'd0) begin
      h_eff = 2'd1;
    end else if (32'(half_taps_q) > MAX_HALF_TAPS) begin
      h_eff = 2'(MAX_HALF_TAPS);
    end else begin
      h_eff = half_taps_q;
    end
    two_h = {h_eff, 1'b0};
    if (frame_width_q == 13'd0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    if (frame_height_q == 15'd0) begin
      ht_eff = HW'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      ht_eff = HW'(MAX_HEIGHT);
    end else begin
      ht_eff = HW'(frame_height_q);
    end
  end

  function automatic logic [1:0] tap_dist(input logic [3:0] i, input logic [1:0] h);
    logic [3:0] hh;
    hh = {2'b00, h};
    tap_dist = (i > hh) ? 2'(i - hh) : 2'(hh - i);
  endfunction

  logic [PW-1:0] weight_sel;
  logic [1:0]    tap_sel;

  always_comb begin
    case (tap_sel)
      2'd0:    weight_sel = tap_center_q;
      2'd1:    weight_sel = tap_one_q;
      2'd2:    weight_sel = tap_two_q;
      default: weight_sel = tap_three_q;
    endcase
  end

  // Sequencer and datapath registers.
  logic [3:0]     state_q;
  logic [IW-1:0]  idx_q;
  logic [PW-1:0]  win_q [WIN_LEN];
  logic [CW-1:0]  col_q, cur_c_q;
  logic [RW-1:0]  row_q, cur_r_q;
  logic [FSW-1:0] fslot_q, cur_fslot_q;
  logic [RSW-1:0] rslot_q, cur_rslot_q;
  logic [AW-1:0]  acc_q;
  logic [FW-1:0]  fcur_q;
  logic [PW-1:0]  cval_q;
  logic           neg_q;
  logic [AW-1:0]  mag_q;
  logic [63:0]    prod_q;
  logic           out_valid_q;
  logic [PW-1:0]  sharp_q;
  logic [CW-1:0]  out_x_q;
  logic [RW-1:0]  out_y_q;
  logic           last_q;

  logic [FW-1:0]  frd_data;
  logic [PW-1:0]  rrd_data;

  logic           in_xfer;
  logic           out_free;
  logic           res_load;
  logic [3:0]     idx4;
  logic [4:0]     fsum;
  logic [FSW-1:0] frd_slot;
  logic [3:0]     rsum;
  logic [RSW-1:0] rrd_slot;
  logic [CW-1:0]  cur_x;
  logic [CW:0]    c_inc;
  logic [RW:0]    r_inc;
  logic [48:0]    diff;
  logic [64:0]    cval_wide, res;
  logic [64:0]    res_rnd;
  logic [32:0]    q_val;
  logic [PW-1:0]  sharp_d;
  logic [AW-1:0]  fround;
  logic           last_d;
  usm_pkg::mem_ctrl_t mem_ctrl;

  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_load = (state_q == S_FIN) && out_free;
  assign idx4     = 4'(idx_q);
  assign cur_x    = cur_c_q - CW'(h_eff);
  assign c_inc    = {1'b0, col_q} + 1'b1;
  assign r_inc    = {1'b0, row_q} + 1'b1;

  // Slot of filtered row r-2h+idx and of raw row r-h, modulo the store depth.
  always_comb begin
    fsum = 5'(cur_fslot_q) + 5'(FROWS) - 5'(two_h) + 5'(idx_q);
    if (fsum >= 5'(FROWS)) begin
      fsum = fsum - 5'(FROWS);
    end
    frd_slot = FSW'(fsum);
    rsum = 4'(cur_rslot_q) + 4'(MAX_HALF_TAPS) - 4'(h_eff);
    if (rsum >= 4'(MAX_HALF_TAPS)) begin
      rsum = rsum - 4'(MAX_HALF_TAPS);
    end
    rrd_slot = RSW'(rsum);
  end

  always_comb begin
    if (state_q == S_VMAC) begin
      tap_sel = (idx_q == '0) ? h_eff : tap_dist(idx4 - 4'd1, h_eff);
    end else begin
      tap_sel = tap_dist(idx4, h_eff);
    end
  end

  always_comb begin
    mem_ctrl.frd = (state_q == S_VMAC) && (idx4 < 4'(two_h));
    mem_ctrl.rrd = (state_q == S_VMAC) && (idx_q == '0);
    mem_ctrl.wr  = (state_q == S_WR);
  end

  always_comb begin
    fround = (acc_q + AW'(128)) >> 8;
    // The raw center value is still on the read port in the difference stage.
    diff   = {9'd0, rrd_data, 24'd0} - {1'b0, acc_q};
    cval_wide = {17'd0, cval_q, 32'd0};
    res       = neg_q ? (cval_wide - {1'b0, prod_q}) : (cval_wide + {1'b0, prod_q});
    res_rnd   = res + (65'd1 << 31);
    q_val     = res_rnd[64:32];
    if (neg_q && ({1'b0, prod_q} > cval_wide)) begin
      sharp_d = '0;
    end else if (q_val > 33'd65535) begin
      sharp_d = '1;
    end else begin
      sharp_d = q_val[PW-1:0];
    end
    last_d = (({1'b0, cur_c_q} + 1'b1) >= (CW+1)'(w_eff))
          && (({1'b0, cur_r_q} + 1'b1) >= (RW+1)'(ht_eff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      fslot_q     <= '0;
      rslot_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            for (int i = WIN_LEN - 1; i > 0; i--) begin
              win_q[i] <= win_q[i-1];
            end
            win_q[0]    <= pixel_value_i;
            cur_c_q     <= col_q;
            cur_r_q     <= row_q;
            cur_fslot_q <= fslot_q;
            cur_rslot_q <= rslot_q;
            idx_q       <= '0;
            if (c_inc >= (CW+1)'(w_eff)) begin
              col_q <= '0;
              if (r_inc >= (RW+1)'(ht_eff)) begin
                row_q   <= '0;
                fslot_q <= '0;
                rslot_q <= '0;
              end else begin
                row_q   <= r_inc[RW-1:0];
                fslot_q <= (fslot_q == FSW'(FROWS - 1)) ? '0 : fslot_q + 1'b1;
                rslot_q <= (rslot_q == RSW'(MAX_HALF_TAPS - 1)) ? '0 : rslot_q + 1'b1;
              end
            end else begin
              col_q <= c_inc[CW-1:0];
            end
            if (col_q >= CW'(two_h)) begin
              state_q <= S_HMAC;
            end
          end
        end
        S_HMAC: begin
          acc_q <= ((idx_q == '0) ? '0 : acc_q) + AW'(weight_sel * win_q[idx_q]);
          idx_q <= idx_q + 1'b1;
          if (idx4 == 4'(two_h)) begin
            state_q <= S_FCUR;
          end
        end
        S_FCUR: begin
          fcur_q <= (fround > AW'(24'hFFFFFF)) ? 24'hFFFFFF : fround[FW-1:0];
          idx_q  <= '0;
          state_q <= (cur_r_q >= RW'(two_h)) ? S_VMAC : S_WR;
        end
        S_VMAC: begin
          // Read data for tap idx-1 returns while tap idx is being addressed.
          if (idx_q == '0) begin
            acc_q <= AW'(weight_sel * fcur_q);
          end else begin
            acc_q <= acc_q + AW'(weight_sel * frd_data);
          end
          idx_q <= idx_q + 1'b1;
          if (idx4 == 4'(two_h)) begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          cval_q  <= rrd_data;
          neg_q   <= diff[48];
          mag_q   <= diff[48] ? AW'(-diff) : diff[AW-1:0];
          state_q <= S_MLO;
        end
        S_MLO: begin
          prod_q  <= 64'(mag_q[23:0] * gain_q);
          state_q <= S_MHI;
        end
        S_MHI: begin
          prod_q  <= prod_q + {40'(mag_q[47:24] * gain_q), 24'd0};
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            sharp_q     <= sharp_d;
            out_x_q     <= cur_x;
            out_y_q     <= cur_r_q - RW'(h_eff);
            last_q      <= last_d;
            state_q     <= S_WR;
          end
        end
        S_WR: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  usm_line_store #(
    .MAX_HALF_TAPS (MAX_HALF_TAPS),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_line_store (
    .clk_i      (clk_i),
    .ctrl_i     (mem_ctrl),
    .x_i        (cur_x),
    .frd_slot_i (frd_slot),
    .rrd_slot_i (rrd_slot),
    .fwr_slot_i (cur_fslot_q),
    .rwr_slot_i (cur_rslot_q),
    .fwr_data_i (fcur_q),
    .rwr_data_i (win_q[IW'(h_eff)]),
    .frd_data_o (frd_data),
    .rrd_data_o (rrd_data)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign sharp_value_o = sharp_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign frame_last_o  = last_q;

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result appeared outside the result stage");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && out_stall_i) |=> state_q == S_FIN)
    else $error("result stage left while the output register was full");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column counter out of range");

  a_write_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> ($past(state_q) == S_FIN || $past(state_q) == S_FCUR))
    else $error("line store written out of sequence");

endmodule

// ===== tb/separable_unsharp_mask_core_test.sv =====
// Self-checking testbench of the separable unsharp mask core.
`timescale 1ns / 1ps

module separable_unsharp_mask_core_test;

  typedef struct {
    logic [15:0] sharp;
    logic [11:0] x;
    logic [13:0] y;
    logic        last;
  } sharp_pix_t;

  typedef struct {
    logic [15:0] pix;
    bit          typed;
    logic [15:0] sharp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = usm_pkg::CFG_HALF_TAPS;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] pixel_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sharp_value_o;
  logic [11:0] out_x_o;
  logic [13:0] out_y_o;
  logic        frame_last_o;

  separable_unsharp_mask_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration and the line state.
  logic [1:0]  m_half;
  logic [15:0] m_tap [4];
  logic [15:0] m_gain;
  logic [12:0] m_width;
  logic [14:0] m_height;
  logic [15:0] m_window [7];
  logic [23:0] m_filt [6][4096];
  logic [15:0] m_raw [3][4096];
  int unsigned m_col, m_row;

  sharp_pix_t  sharp_q[$];
  int          fails = 0;
  int          results_seen = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          pressure_req = 1'b0;
  logic        rx_hold = 1'b0;

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic longint unsigned tap_at(int unsigned dst);
    return (dst > 3) ? m_tap[3] : m_tap[dst];
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      usm_pkg::CFG_HALF_TAPS:    m_half = val[1:0];
      usm_pkg::CFG_TAP_CENTER:   m_tap[0] = val;
      usm_pkg::CFG_TAP_ONE:      m_tap[1] = val;
      usm_pkg::CFG_TAP_TWO:      m_tap[2] = val;
      usm_pkg::CFG_TAP_THREE:    m_tap[3] = val;
      usm_pkg::CFG_SHARPEN_GAIN: m_gain = val;
      usm_pkg::CFG_FRAME_WIDTH:  m_width = val[12:0];
      usm_pkg::CFG_FRAME_HEIGHT: m_height = val[14:0];
      default: ;
    endcase
  endfunction

  // Advances the line state by one pixel and queues the sharpened pixel it completes.
  function automatic void sharpen_pixel(logic [15:0] p, bit typed, logic [15:0] typed_val);
    int unsigned h, w, ht, c, r, x, d, rw;
    longint unsigned acc, fcur, blur, cval;
    longint signed diff, res;
    longint unsigned q;
    sharp_pix_t e;
    h = (m_half == 0) ? 1 : m_half;
    w = (m_width == 0) ? 1 : ((m_width > 4096) ? 4096 : m_width);
    ht = (m_height == 0) ? 1 : ((m_height > 16384) ? 16384 : m_height);
    c = (m_col > 4095) ? 4095 : m_col;
    r = m_row;
    for (int i = 6; i > 0; i--) m_window[i] = m_window[i-1];
    m_window[0] = p;
    if (c >= 2 * h) begin
      x = c - h;
      acc = 0;
      for (int i = 0; i <= 2 * h; i++) begin
        d = (i > h) ? i - h : h - i;
        acc += tap_at(d) * longint'(m_window[i]);
      end
      fcur = (acc + 128) >> 8;
      if (fcur > 64'hFFFFFF) fcur = 64'hFFFFFF;
      if (r >= 2 * h) begin
        cval = m_raw[(r - h) % 3][x];
        blur = tap_at(h) * fcur;
        for (int i = 0; i < 2 * h; i++) begin
          rw = r - 2 * h + i;
          d = (i > h) ? i - h : h - i;
          blur += tap_at(d) * longint'(m_filt[rw % 6][x]);
        end
        diff = longint'(cval << 24) - longint'(blur);
        res = longint'(cval << 32) + diff * longint'(m_gain);
        if (res < 0) e.sharp = 0;
        else begin
          q = (longint'(res) + 64'h80000000) >> 32;
          e.sharp = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        if (typed) e.sharp = typed_val;
        e.x = x[11:0];
        e.y = 14'(r - h);
        e.last = (c + 1 >= w) && (r + 1 >= ht);
        sharp_q.push_back(e);
      end
      m_filt[r % 6][x] = fcur[23:0];
      m_raw[r % 3][x] = m_window[h];
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= ht) r = 0;
    end
    m_col = c;
    m_row = r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [15:0] p, bit typed, logic [15:0] typed_val);
    while (chance(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_value_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sharpen_pixel(p, typed, typed_val);
  endtask

  // Lets the pipeline drain after the last transfer of a phase.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  task automatic send_frames(int unsigned n, int unsigned frames);
    for (int unsigned i = 0; i < n * frames; i++)
      send_pixel(16'($urandom), 1'b0, '0);
  endtask

  function automatic logic [15:0] rand_tap();
    case ($urandom_range(5, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(4096, 0));
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: check each transfer against the oldest expectation, then pick the next stall.
  always @(posedge clk_i) begin
    sharp_pix_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (sharp_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result x=%0d y=%0d", out_x_o, out_y_o);
      end else begin
        e = sharp_q.pop_front();
        if (e.sharp !== sharp_value_o || e.x !== out_x_o || e.y !== out_y_o ||
            e.last !== frame_last_o) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp %0d (%0d,%0d) last %0d, got %0d (%0d,%0d) last %0d",
                     e.sharp, e.x, e.y, e.last, sharp_value_o, out_x_o, out_y_o,
                     frame_last_o);
        end
      end
    end
    out_stall_i <= rx_hold || chance(recv_stall_pct);
  end

  // Long receiver hold-off so that the core fills up and stalls its input.
  initial begin
    wait (pressure_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  dir_row_t dir_tbl[25];
  int unsigned sent;
  int unsigned n_frames;
  int phase;
  logic [15:0] w_sel, h_sel;

  initial begin
    m_half = 1; m_tap[0] = 16'hFFFF; m_tap[1] = 0; m_tap[2] = 0; m_tap[3] = 0;
    m_gain = 0; m_width = 4096; m_height = 1;
    foreach (m_window[i]) m_window[i] = '0;
    m_col = 0; m_row = 0;
    // 5x5 frame, pass-through taps and zero gain: each result equals the raw pixel.
    dir_tbl = '{
      '{16'd0, 0, 0}, '{16'd65535, 0, 0}, '{16'd1, 0, 0}, '{16'd32768, 0, 0},
      '{16'd7, 0, 0},
      '{16'd65535, 0, 0}, '{16'd0, 0, 0}, '{16'd65535, 0, 0}, '{16'd100, 0, 0},
      '{16'd2, 0, 0},
      '{16'd3, 0, 0}, '{16'd40000, 0, 0}, '{16'd0, 1, 16'd0}, '{16'd65535, 1, 16'd65535},
      '{16'd9, 1, 16'd100},
      '{16'd11, 0, 0}, '{16'd1, 0, 0}, '{16'd32767, 1, 16'd40000}, '{16'd12345, 1, 16'd0},
      '{16'd8, 1, 16'd65535},
      '{16'd4, 0, 0}, '{16'd5, 0, 0}, '{16'd6, 1, 16'd1}, '{16'd65534, 1, 16'd32767},
      '{16'd10, 1, 16'd12345}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd5);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd5);
    foreach (dir_tbl[i]) send_pixel(dir_tbl[i].pix, dir_tbl[i].typed, dir_tbl[i].sharp);
    drain();

    // Frame too small for the kernel: nothing comes out.
    write_reg(usm_pkg::CFG_HALF_TAPS, 16'd3);
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd6);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd9);
    send_frames(54, 1);
    drain();

    // Zero half width acts as one, with full-scale taps and gain.
    write_reg(usm_pkg::CFG_HALF_TAPS, 16'd0);
    write_reg(usm_pkg::CFG_TAP_ONE, 16'hFFFF);
    write_reg(usm_pkg::CFG_TAP_TWO, 16'hFFFF);
    write_reg(usm_pkg::CFG_TAP_THREE, 16'hFFFF);
    write_reg(usm_pkg::CFG_SHARPEN_GAIN, 16'hFFFF);
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd8);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd5);
    send_frames(40, 1);
    drain();

    // Zero width and zero height act as one.
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd0);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd0);
    send_frames(1, 3);
    drain();

    sent = 0;
    phase = 0;
    while (sent < 730) begin
      set_idling(phase);
      write_reg(usm_pkg::CFG_HALF_TAPS, 16'($urandom_range(3, 0)));
      write_reg(usm_pkg::CFG_TAP_CENTER, rand_tap());
      write_reg(usm_pkg::CFG_TAP_ONE, rand_tap());
      write_reg(usm_pkg::CFG_TAP_TWO, rand_tap());
      write_reg(usm_pkg::CFG_TAP_THREE, rand_tap());
      case ($urandom_range(3, 0))
        0: write_reg(usm_pkg::CFG_SHARPEN_GAIN, 16'h0000);
        1: write_reg(usm_pkg::CFG_SHARPEN_GAIN, 16'hFFFF);
        2: write_reg(usm_pkg::CFG_SHARPEN_GAIN, 16'($urandom_range(1024, 0)));
        default: write_reg(usm_pkg::CFG_SHARPEN_GAIN, 16'($urandom));
      endcase
      w_sel = 16'($urandom_range(16, 1));
      h_sel = 16'($urandom_range(12, 1));
      write_reg(usm_pkg::CFG_FRAME_WIDTH, w_sel);
      write_reg(usm_pkg::CFG_FRAME_HEIGHT, h_sel);
      if (phase == 2) pressure_req = 1'b1;
      n_frames = $urandom_range(3, 1);
      send_frames(w_sel * h_sel, n_frames);
      sent += w_sel * h_sel * n_frames;
      drain();
      phase++;
    end

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/usm_pkg.sv
design/usm_line_store.sv
design/separable_unsharp_mask_core.sv
tb/separable_unsharp_mask_core_test.sv
